FILE: rtl/core/kvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value table: request and result
// payloads, operation codes, table sizing and sequencer states.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int ENTRY_W  = 5;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [DATA_W-1:0]  lookup_key;
		logic signed [DATA_W-1:0]  new_value;
	} kvt_req_t;

	typedef struct packed {
		logic                      hit;
		logic signed [DATA_W-1:0]  prior_value;
		logic                      status;
		logic [ENTRY_W-1:0]        entry_total;
		logic [DATA_W-1:0]         value_span;
	} kvt_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} kvt_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/key_value_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_value_table
// Fixed-capacity unsorted key/value table with add, search and remove.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. One scan walks the
// stored entries through the single read port of the key and value memories,
// one entry per cycle, comparing keys and tracking min and max of the values
// that remain after the operation; the DONE state then writes the table.
// The result appears for one cycle with done high and cannot be stalled, so
// the receiver must take it in that cycle. A new request may start in the
// cycle the result is shown. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module key_value_table
	import kvt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire kvt_req_t request,
	output logic          done,
	output kvt_rsp_t      result
);

	// table memories
	logic [DATA_W-1:0] key_mem [CAPACITY];
	logic [DATA_W-1:0] val_mem [CAPACITY];

	kvt_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] addr_q;
	logic             rd_vld_q;
	logic             done_q;

	logic [IDX_W-1:0]         rd_idx_q;
	logic [DATA_W-1:0]        key_rd_q;
	logic signed [DATA_W-1:0] val_rd_q;

	logic [1:0]               mode_q;
	logic [DATA_W-1:0]        key_q;
	logic signed [DATA_W-1:0] val_q;
	logic                     hit_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic signed [DATA_W-1:0] old_q;
	logic                     have_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic [DATA_W-1:0]        last_key_q;
	logic [DATA_W-1:0]        last_val_q;
	kvt_rsp_t                 result_q;

	logic             accept;
	logic             issue;
	logic [IDX_W-1:0] rd_addr;
	logic             match;
	logic             keep;
	logic             is_last;

	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic [DATA_W-1:0]        wr_key;
	logic [DATA_W-1:0]        wr_val;
	logic                     add_new;
	logic                     full;
	logic [CNT_W-1:0]         count_d;
	logic signed [DATA_W-1:0] fin_min;
	logic signed [DATA_W-1:0] fin_max;
	logic [DATA_W-1:0]        span;
	kvt_rsp_t                 rsp_d;

	assign accept  = start && (state_q == ST_IDLE);
	assign rd_addr = addr_q[IDX_W-1:0];
	assign match   = (key_rd_q == key_q);
	// the matching entry drops out of the span for add and remove
	assign keep    = !match || ((mode_q != MODE_ADD) && (mode_q != MODE_REMOVE));
	assign is_last = (CNT_W'(rd_idx_q) == (count_q - CNT_W'(1)));
	assign full    = (count_q == CNT_W'(CAPACITY));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!issue && !rd_vld_q) state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy  = (state_q != ST_IDLE);
		issue = (state_q == ST_SCAN) && (addr_q < count_q);
	end

	// final update and result
	always_comb begin
		add_new = (mode_q == MODE_ADD) && (hit_q || !full);
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_key  = key_q;
		wr_val  = val_q;
		count_d = count_q;
		if (mode_q == MODE_ADD) begin
			if (hit_q) begin
				wr_en = 1'b1;
			end else if (!full) begin
				wr_en   = 1'b1;
				wr_addr = count_q[IDX_W-1:0];
				count_d = count_q + CNT_W'(1);
			end
		end else if ((mode_q == MODE_REMOVE) && hit_q) begin
			wr_en   = 1'b1;
			wr_key  = last_key_q;
			wr_val  = last_val_q;
			count_d = count_q - CNT_W'(1);
		end

		fin_min = min_q;
		fin_max = max_q;
		if (add_new) begin
			if (!have_q || (val_q < min_q)) fin_min = val_q;
			if (!have_q || (val_q > max_q)) fin_max = val_q;
		end
		span = (count_d >= CNT_W'(2)) ? DATA_W'(fin_max - fin_min) : '0;

		rsp_d.hit         = hit_q;
		rsp_d.prior_value = old_q;
		rsp_d.status      = (mode_q == MODE_ADD) && !hit_q && full;
		rsp_d.entry_total = ENTRY_W'(count_d);
		rsp_d.value_span  = span;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			addr_q   <= '0;
			rd_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= (state_q == ST_DONE);
			rd_vld_q <= issue;
			if (accept) begin
				addr_q <= '0;
			end else if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			if (state_q == ST_DONE) count_q <= count_d;
		end
	end

	// memory port: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en && (state_q == ST_DONE)) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
		key_rd_q <= key_mem[rd_addr];
		val_rd_q <= val_mem[rd_addr];
		rd_idx_q <= rd_addr;
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= request.mode;
			key_q  <= request.lookup_key;
			val_q  <= request.new_value;
			hit_q  <= 1'b0;
			old_q  <= '0;
			have_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && rd_vld_q) begin
			if (match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_q;
				old_q     <= val_rd_q;
			end
			if (keep) begin
				have_q <= 1'b1;
				if (!have_q || (val_rd_q < min_q)) min_q <= val_rd_q;
				if (!have_q || (val_rd_q > max_q)) max_q <= val_rd_q;
			end
			if (is_last) begin
				last_key_q <= key_rd_q;
				last_val_q <= val_rd_q;
			end
		end
		if (state_q == ST_DONE) result_q <= rsp_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

FILE: test/key_value_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_value_table_test
// Self-checking bench for the key/value table. A short table of directed
// requests covers the empty table, extreme keys and values, updates, removal
// with the last entry moving into the hole, the unused mode and a full table.
// Random requests follow in phases that grow, churn and drain the table.
// Each result is checked against its pinned row value or a shadow table copy.
// ----------------------------------------------------------------------------
module key_value_table_test;
	import kvt_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 25;
	localparam int RANDOM_REQUESTS = 1800;
	localparam int DIRECTED_ROWS   = 25;
	localparam int POOL_SIZE       = 24;

	typedef struct {
		bit       pinned;
		kvt_rsp_t rsp;
	} golden_t;

	typedef struct {
		kvt_req_t req;
		bit       pinned;
		kvt_rsp_t rsp;
	} row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	kvt_req_t request;
	logic     busy;
	logic     done;
	kvt_rsp_t result;

	// shadow copy of the table
	logic [DATA_W-1:0] shadow_keys [CAPACITY];
	logic [DATA_W-1:0] shadow_vals [CAPACITY];
	int                shadow_count = 0;

	golden_t issued_q [$];
	golden_t awaited_rsp [$];
	bit      failed = 1'b0;
	int      idle_cycles = 0;

	key_value_table dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #5 clk = ~clk;

	function automatic kvt_req_t mk_req(logic [1:0] mode, logic [31:0] key, logic [31:0] val);
		kvt_req_t r;
		r.mode       = mode;
		r.lookup_key = key;
		r.new_value  = val;
		return r;
	endfunction

	function automatic kvt_rsp_t mk_rsp(logic hit, logic [31:0] old, logic st,
		logic [ENTRY_W-1:0] total, logic [31:0] span);
		kvt_rsp_t r;
		r.hit         = hit;
		r.prior_value = old;
		r.status      = st;
		r.entry_total = total;
		r.value_span  = span;
		return r;
	endfunction

	// applies one request to the shadow table and returns its result
	function automatic kvt_rsp_t apply_request(kvt_req_t req);
		int                slot;
		kvt_rsp_t          r;
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		slot = -1;
		for (int i = 0; i < shadow_count; i++)
			if (slot < 0 && shadow_keys[i] == req.lookup_key)
				slot = i;
		r = '0;
		if (slot >= 0) begin
			r.hit         = 1'b1;
			r.prior_value = shadow_vals[slot];
		end
		case (req.mode)
			MODE_ADD: begin
				if (slot >= 0) begin
					shadow_vals[slot] = req.new_value;
				end else if (shadow_count < CAPACITY) begin
					shadow_keys[shadow_count] = req.lookup_key;
					shadow_vals[shadow_count] = req.new_value;
					shadow_count++;
				end else begin
					r.status = 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (slot >= 0) begin
					// last entry fills the hole
					shadow_count--;
					shadow_keys[slot] = shadow_keys[shadow_count];
					shadow_vals[slot] = shadow_vals[shadow_count];
				end
			end
			default: ;
		endcase
		r.entry_total = ENTRY_W'(shadow_count);
		if (shadow_count >= 2) begin
			hi = shadow_vals[0];
			lo = shadow_vals[0];
			for (int i = 1; i < shadow_count; i++) begin
				if ($signed(shadow_vals[i]) > hi) hi = shadow_vals[i];
				if ($signed(shadow_vals[i]) < lo) lo = shadow_vals[i];
			end
			r.value_span = hi - lo;
		end
		return r;
	endfunction

	task automatic check_result(kvt_rsp_t want, kvt_rsp_t got);
		if (got.hit !== want.hit) begin
			$display("%0t: hit expected %0d, got %0d", $time, want.hit, got.hit);
			failed = 1'b1;
		end
		if (got.prior_value !== want.prior_value) begin
			$display("%0t: prior_value expected %0d, got %0d", $time,
				want.prior_value, got.prior_value);
			failed = 1'b1;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
			failed = 1'b1;
		end
		if (got.entry_total !== want.entry_total) begin
			$display("%0t: entry_total expected %0d, got %0d", $time,
				want.entry_total, got.entry_total);
			failed = 1'b1;
		end
		if (got.value_span !== want.value_span) begin
			$display("%0t: value_span expected %h, got %h", $time,
				want.value_span, got.value_span);
			failed = 1'b1;
		end
	endtask

	// results first, so a request taken in the same cycle queues behind them
	always @(posedge clk) begin : monitor
		golden_t g;
		bit      moved;
		moved = 1'b0;
		if (arst_n) begin
			if (done) begin
				moved = 1'b1;
				if (awaited_rsp.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, result);
					failed = 1'b1;
				end else begin
					g = awaited_rsp.pop_front();
					check_result(g.rsp, result);
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				g = issued_q.pop_front();
				if (!g.pinned)
					g.rsp = apply_request(request);
				else
					void'(apply_request(request));
				awaited_rsp.push_back(g);
			end
		end
		idle_cycles <= moved ? 0 : idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic issue(kvt_req_t req, bit pinned, kvt_rsp_t want, bit steady);
		int      gap;
		golden_t g;
		gap = pick_gap(steady);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		g.pinned = pinned;
		g.rsp    = want;
		issued_q.push_back(g);
		start   <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
	endtask

	initial begin : stimulus
		row_t              rows [DIRECTED_ROWS];
		logic [DATA_W-1:0] key_pool [POOL_SIZE];
		logic [DATA_W-1:0] edge_vals [4];
		logic [1:0]        mode;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] val;
		int                phase;
		int                r;

		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;

		edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
		foreach (key_pool[i])
			key_pool[i] = (i < 4) ? edge_vals[i] : $urandom;

		// empty table, extremes, update, remove and the unused mode
		rows[0] = '{mk_req(MODE_SEARCH, 32'h0, 32'h0), 1, mk_rsp(0, 0, 0, 0, 0)};
		rows[1] = '{mk_req(MODE_REMOVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 1,
			mk_rsp(0, 0, 0, 0, 0)};
		rows[2] = '{mk_req(MODE_SPARE, 32'h5, 32'h5), 1, mk_rsp(0, 0, 0, 0, 0)};
		rows[3] = '{mk_req(MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF), 1,
			mk_rsp(0, 0, 0, 1, 0)};
		rows[4] = '{mk_req(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000), 1,
			mk_rsp(0, 0, 0, 2, 32'hFFFF_FFFF)};
		rows[5] = '{mk_req(MODE_ADD, 32'h8000_0000, 32'h1234_5678), 1,
			mk_rsp(1, 32'h7FFF_FFFF, 0, 2, 32'h9234_5678)};
		rows[6] = '{mk_req(MODE_REMOVE, 32'h8000_0000, 32'h0), 1,
			mk_rsp(1, 32'h1234_5678, 0, 1, 0)};
		rows[7] = '{mk_req(MODE_SPARE, 32'h7FFF_FFFF, 32'h0), 1,
			mk_rsp(1, 32'h8000_0000, 0, 1, 0)};
		// fill to capacity with mixed-sign keys
		for (int i = 8; i < 23; i++) begin
			key = (i % 2) ? -(i - 7) : (i - 7);
			rows[i] = '{mk_req(MODE_ADD, key, $urandom), 0, '0};
		end
		// new key into a full table, then an update while full
		rows[23] = '{mk_req(MODE_ADD, 32'h5A5A_5A5A, 32'h1), 0, '0};
		rows[24] = '{mk_req(MODE_ADD, 32'h7FFF_FFFF, 32'h0), 0, '0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			issue(rows[i].req, rows[i].pinned, rows[i].rsp, 1'b0);

		// phases: grow toward full, churn, drain toward empty
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			phase = (n / 150) % 3;
			r = $urandom_range(0, 99);
			if (r < 3)
				mode = MODE_SPARE;
			else if (r < (phase == 0 ? 73 : phase == 1 ? 40 : 18))
				mode = MODE_ADD;
			else if (r < (phase == 0 ? 85 : phase == 1 ? 70 : 88))
				mode = MODE_REMOVE;
			else
				mode = MODE_SEARCH;
			key = ($urandom_range(0, 9) == 0) ? $urandom
				: key_pool[$urandom_range(0, POOL_SIZE - 1)];
			val = ($urandom_range(0, 4) == 0) ? edge_vals[$urandom_range(0, 3)] : $urandom;
			issue(mk_req(mode, key, val), 1'b0, '0, ((n / 100) % 4) == 3);
		end
		start <= 1'b0;
		@(posedge clk);

		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/kvt_pkg.sv
rtl/core/key_value_table.sv
test/key_value_table_test.sv
